>>> src/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUT,
    S_SCROLL_COPY,
    S_SCROLL_BLANK,
    S_CLEAR,
    S_DRAW,
    S_READ,
    S_RESP
  } state_e;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_CLEAR = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic CFG_TEXT_ATTR   = 1'b0;
  localparam logic CFG_CURSOR_ATTR = 1'b1;

  localparam logic [7:0] TEXT_ATTR_RESET   = 8'h07;
  localparam logic [7:0] CURSOR_ATTR_RESET = 8'h70;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] PRINT_LO     = 8'h20;
  localparam logic [7:0] PRINT_HI     = 8'h7E;

endpackage

>>> src/tcw_cell_ram.sv
// Cell store of the console: one write port and one registered read port.
module tcw_cell_ram #(
  parameter int DEPTH  = 2000,
  parameter int ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [15:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [15:0]       rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/text_console_writer_unit.sv
// Top level of the text console writer: sequencer, cursor and cell store.
// A printable byte, a newline without scroll or an ignored byte passes through S_PUT,
// S_DRAW and S_RESP; a read through S_READ and S_RESP, an unused mode through S_RESP.
// All work goes through the single write port of the cell store: a scroll adds a copy
// pass moving each row up and a blanking pass over the bottom row, and clear mode writes
// every cell. After reset the store is cleared by a pass over every cell during which no
// transaction is accepted on the input; configuration writes are always taken. A result
// waiting on the output does not block the next input transaction.
module text_console_writer_unit #(
  parameter int ROWS    = 25,
  parameter int COLUMNS = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // cursor_row[4:0], cursor_col[11:5],
                                     // cell_char[19:12], cell_attribute[27:20]
  output logic [0:0]  m_axis_tuser,  // scrolled[0]
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  localparam int N      = ROWS * COLUMNS;
  localparam int COPY_N = (ROWS - 1) * COLUMNS;
  localparam int AW     = $clog2(N);
  localparam int CW     = $clog2(N + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  tcw_pkg::state_e state_q, state_d;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [AW-1:0]    addr_q, addr_d;
  logic             emit_q, emit_d;
  logic             scrolled_q, scrolled_d;
  logic             hit_q, hit_d;
  logic             m_valid_q;
  logic [31:0]      m_data_q;
  logic [0:0]       m_user_q;
  logic [7:0]       text_attr_q, cursor_attr_q;

  logic [1:0] mode_q;
  logic [7:0] char_q;
  logic [4:0] rrow_q;
  logic [6:0] rcol_q;

  logic          wr_en, rd_en, load_out, in_hs;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [15:0]   wr_data, rd_data;
  logic [31:0]   row_ext, col_ext;
  logic [7:0]    out_char, out_attr;

  assign in_hs         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == tcw_pkg::S_IDLE);
  assign cfg_ready_o   = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_attr_q   <= tcw_pkg::TEXT_ATTR_RESET;
      cursor_attr_q <= tcw_pkg::CURSOR_ATTR_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tcw_pkg::CFG_TEXT_ATTR) begin
        text_attr_q <= cfg_data_i;
      end else begin
        cursor_attr_q <= cfg_data_i;
      end
    end
  end

  // Item fields, held for the length of the item's work.
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      mode_q <= s_axis_tuser;
      char_q <= s_axis_tdata[7:0];
      rrow_q <= s_axis_tdata[12:8];
      rcol_q <= s_axis_tdata[19:13];
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    addr_d     = addr_q;
    emit_d     = emit_q;
    scrolled_d = scrolled_q;
    hit_d      = hit_q;
    wr_en      = 1'b0;
    wr_addr    = addr_q;
    wr_data    = {text_attr_q, tcw_pkg::BLANK_CHAR};
    rd_en      = 1'b0;
    rd_addr    = '0;
    load_out   = 1'b0;

    unique case (state_q)
      tcw_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          emit_d     = 1'b1;
          scrolled_d = 1'b0;
          hit_d      = 1'b0;
          unique case (s_axis_tuser)
            tcw_pkg::MODE_PUT:  state_d = tcw_pkg::S_PUT;
            tcw_pkg::MODE_CLEAR: begin
              state_d = tcw_pkg::S_CLEAR;
              cnt_d   = '0;
            end
            tcw_pkg::MODE_READ: state_d = tcw_pkg::S_READ;
            default:            state_d = tcw_pkg::S_RESP;
          endcase
        end
      end

      tcw_pkg::S_PUT: begin
        state_d = tcw_pkg::S_DRAW;
        if (char_q >= tcw_pkg::PRINT_LO && char_q <= tcw_pkg::PRINT_HI) begin
          wr_en   = 1'b1;
          wr_data = {text_attr_q, char_q};
          if (col_q == COL_W'(COLUMNS - 1)) begin
            if (row_q == ROW_W'(ROWS - 1)) begin
              scrolled_d = 1'b1;
              cnt_d      = '0;
              state_d    = tcw_pkg::S_SCROLL_COPY;
              col_d      = '0;
              addr_d     = AW'(COPY_N);
            end else begin
              row_d  = row_q + 1'b1;
              col_d  = '0;
              addr_d = addr_q + 1'b1;
            end
          end else begin
            col_d  = col_q + 1'b1;
            addr_d = addr_q + 1'b1;
          end
        end else if (char_q == tcw_pkg::NEWLINE_CHAR) begin
          wr_en = 1'b1;
          col_d = '0;
          if (row_q != ROW_W'(ROWS - 1)) begin
            row_d  = row_q + 1'b1;
            addr_d = AW'(32'(addr_q) + COLUMNS - 32'(col_q));
          end else begin
            scrolled_d = 1'b1;
            cnt_d      = '0;
            state_d    = tcw_pkg::S_SCROLL_COPY;
            addr_d     = AW'(COPY_N);
          end
        end
      end

      // Read cell cnt+COLUMNS and write the cell read on the previous cycle to cnt-1.
      tcw_pkg::S_SCROLL_COPY: begin
        if (cnt_q != CW'(COPY_N)) begin
          rd_en   = 1'b1;
          rd_addr = AW'(32'(cnt_q) + COLUMNS);
        end
        if (cnt_q != '0) begin
          wr_en   = 1'b1;
          wr_addr = AW'(cnt_q - 1'b1);
          wr_data = rd_data;
        end
        if (cnt_q == CW'(COPY_N)) begin
          state_d = tcw_pkg::S_SCROLL_BLANK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end

      tcw_pkg::S_SCROLL_BLANK: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[AW-1:0];
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CW'(N - 1)) begin
          state_d = tcw_pkg::S_DRAW;
        end
      end

      tcw_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = cnt_q[AW-1:0];
        cnt_d   = cnt_q + 1'b1;
        row_d   = '0;
        col_d   = '0;
        addr_d  = '0;
        if (cnt_q == CW'(N - 1)) begin
          state_d = tcw_pkg::S_DRAW;
        end
      end

      tcw_pkg::S_DRAW: begin
        wr_en   = 1'b1;
        wr_data = {cursor_attr_q, tcw_pkg::BLANK_CHAR};
        state_d = emit_q ? tcw_pkg::S_RESP : tcw_pkg::S_IDLE;
      end

      tcw_pkg::S_READ: begin
        hit_d   = (32'(rrow_q) < ROWS) && (32'(rcol_q) < COLUMNS);
        rd_en   = hit_d;
        rd_addr = AW'(32'(rrow_q) * COLUMNS + 32'(rcol_q));
        state_d = tcw_pkg::S_RESP;
      end

      tcw_pkg::S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = tcw_pkg::S_IDLE;
        end
      end

      default: state_d = tcw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tcw_pkg::S_CLEAR;
      cnt_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
      addr_q     <= '0;
      emit_q     <= 1'b0;
      scrolled_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      addr_q     <= addr_d;
      emit_q     <= emit_d;
      scrolled_q <= scrolled_d;
      hit_q      <= hit_d;
    end
  end

  tcw_cell_ram #(
    .DEPTH  (N),
    .ADDR_W (AW)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign row_ext  = 32'(row_q);
  assign col_ext  = 32'(col_q);
  assign out_char = (hit_q && mode_q == tcw_pkg::MODE_READ) ? rd_data[7:0]  : 8'h00;
  assign out_attr = (hit_q && mode_q == tcw_pkg::MODE_READ) ? rd_data[15:8] : 8'h00;

  // Output register; it frees the sequencer while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= {4'h0, out_attr, out_char, col_ext[6:0], row_ext[4:0]};
      m_user_q <= scrolled_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

`ifndef ASSERT_OFF
  a_cursor_linear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::S_IDLE |-> 32'(addr_q) == 32'(row_q) * COLUMNS + 32'(col_q))
    else $error("cursor address does not match row and column");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(row_q) < ROWS && 32'(col_q) < COLUMNS)
    else $error("cursor outside the screen");

  a_scroll_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tcw_pkg::S_SCROLL_COPY || state_q == tcw_pkg::S_SCROLL_BLANK)
      |-> (32'(addr_q) == COPY_N && scrolled_q))
    else $error("scroll without the cursor at the start of the bottom row");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_hs |=> !s_axis_tready)
    else $error("input ready right after a transaction");
`endif

endmodule
